// ===== rtl/mcma_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel moving average package
// Shared constants and types for the per-scan sample vectors.
// ----------------------------------------------------------------------------
package mcma_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int SCAN_BITS   = CHANNELS * SAMPLE_BITS;
    localparam int TDATA_W     = ((SCAN_BITS + 7) / 8) * 8;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [CHANNELS-1:0] t_scan;

endpackage

// ===== rtl/mcma_cell.sv =====
// ----------------------------------------------------------------------------
// Moving average window cell
// One slot of the sample window; holds one scan and hands it to the next
// cell whenever a new scan enters the chain.
// ----------------------------------------------------------------------------
module mcma_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  mcma_pkg::t_scan i_scan,
    output mcma_pkg::t_scan o_scan
);
    import mcma_pkg::*;

    t_scan r_scan;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_scan <= i_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== rtl/mcma_div.sv =====
// ----------------------------------------------------------------------------
// Moving average divider
// Divides a channel sum by the fill count through a registered multiply by
// a rounded-up reciprocal; the shifted product is the exact truncated mean.
// ----------------------------------------------------------------------------
module mcma_div #(
    parameter int SUM_W   = 15,
    parameter int RECIP_W = 19,
    parameter int SHIFT   = 18
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SUM_W-1:0]    i_sum,
    input  logic [RECIP_W-1:0]  i_recip,
    output mcma_pkg::t_sample   o_quot
);
    import mcma_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(i_recip);
        end
    end

    assign o_quot = r_prod[SHIFT +: SAMPLE_BITS];

endmodule

// ===== rtl/multichannel_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// Multichannel moving average core
// Boxcar mean over the last WINDOW scans of each channel, with warm-up
// averaging over the scans seen so far.
// ----------------------------------------------------------------------------
//   Channel   Direction  Fields (low bits first)
//   s_axis    in         sample_ch0, sample_ch1, sample_ch2, sample_ch3
//   m_axis    out        avg_ch0, avg_ch1, avg_ch2, avg_ch3
//
// One scan is accepted per cycle while m_axis is not stalled; each result passes
// through the sum update, the reciprocal multiply and the output register.
// The sample window is a shift chain of WINDOW cells, so no memory clearing
// is needed after reset; reset clears the sums, fill count and valid flags.
// A stall on m_axis holds the whole pipeline and deasserts s_axis_tready.
// ----------------------------------------------------------------------------
module multichannel_moving_average_core #(
    parameter int WINDOW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  logic [mcma_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // avg_ch0, avg_ch1, avg_ch2, avg_ch3
    output logic [mcma_pkg::TDATA_W-1:0]  m_axis_tdata
);
    import mcma_pkg::*;

    localparam int WIN_W   = $clog2(WINDOW);
    localparam int SUM_W   = SAMPLE_BITS + WIN_W;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SHIFT   = SUM_W + WIN_W;
    localparam int RECIP_W = SHIFT + 1;

    logic                w_adv;
    logic                w_acc;
    logic                w_full;
    logic [CNT_W-1:0]    w_div;
    t_scan               w_in_scan;
    t_scan               w_chain [0:WINDOW];
    logic [RECIP_W-1:0]  w_recip_tab [0:WINDOW];
    logic [SUM_W:0]      w_sum_ext [CHANNELS];
    t_scan               w_quot;

    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum [CHANNELS];
    logic [SUM_W-1:0]    n_sum [CHANNELS];
    logic [RECIP_W-1:0]  r_recip;
    logic                r_v1;
    logic                r_v2;
    logic                r_out_vld;
    t_scan               r_out_scan;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;
    assign w_in_scan     = s_axis_tdata[SCAN_BITS-1:0];
    assign w_full        = (r_fill == CNT_W'(WINDOW));
    assign w_div         = w_full ? CNT_W'(WINDOW) : r_fill + CNT_W'(1);

    assign w_chain[0] = w_in_scan;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        mcma_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_acc),
            .i_scan  (w_chain[i]),
            .o_scan  (w_chain[i+1])
        );
    end

    for (genvar d = 0; d <= WINDOW; d++) begin : g_recip
        if (d == 0) begin : g_zero
            assign w_recip_tab[d] = '0;
        end else begin : g_val
            localparam logic [RECIP_W-1:0] L_RECIP =
                RECIP_W'(((64'd1 << SHIFT) + 64'(d) - 64'd1) / 64'(d));
            assign w_recip_tab[d] = L_RECIP;
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_sum_ext[c] = {1'b0, r_sum[c]} + (SUM_W+1)'(w_in_scan[c])
                         - (w_full ? (SUM_W+1)'(w_chain[WINDOW][c]) : '0);
            n_sum[c] = w_acc ? w_sum_ext[c][SUM_W-1:0] : r_sum[c];
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_div
        mcma_div #(
            .SUM_W   (SUM_W),
            .RECIP_W (RECIP_W),
            .SHIFT   (SHIFT)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_sum   (r_sum[c]),
            .i_recip (r_recip),
            .o_quot  (w_quot[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_out_vld <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= n_sum[c];
            end
            if (w_acc && !w_full) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (w_adv) begin
                r_v1      <= w_acc;
                r_v2      <= r_v1;
                r_out_vld <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_recip <= w_recip_tab[w_div];
        end
        if (w_adv) begin
            r_out_scan <= w_quot;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDATA_W'(r_out_scan);

endmodule

// ===== tb/sv/mcma_avg_checker.sv =====
// ----------------------------------------------------------------------------
// Moving average result checker
// Watches both stream channels of the moving average core. It keeps its own
// copy of the sample windows, running sums and fill count, works out the
// expected averages of every accepted scan, and compares each accepted
// result channel by channel with the oldest expected one.
// ----------------------------------------------------------------------------
module mcma_avg_checker #(
    parameter int WINDOW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  logic [mcma_pkg::TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // avg_ch0, avg_ch1, avg_ch2, avg_ch3
    input  logic [mcma_pkg::TDATA_W-1:0]  i_m_axis_tdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import mcma_pkg::*;

    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int FILL_BITS = $clog2(WINDOW + 1);

    t_sample              history [CHANNELS][WINDOW];
    logic [SUM_BITS-1:0]  run_sum [CHANNELS];
    logic [FILL_BITS-1:0] fill_cnt;
    int                   oldest_slot;
    t_scan                expected_avgs [$];
    int                   result_idx;

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", result_idx, msg);
        o_fail_count++;
    endtask

    function automatic t_scan predict_averages(input t_scan samples);
        t_scan                avgs;
        logic [FILL_BITS-1:0] divisor;
        int                   slot;
        logic                 full;
        full = (fill_cnt >= WINDOW);
        if (full) begin
            slot    = oldest_slot;
            divisor = FILL_BITS'(WINDOW);
        end else begin
            slot     = int'(fill_cnt);
            fill_cnt = fill_cnt + 1'b1;
            divisor  = fill_cnt;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (full) begin
                run_sum[c] = run_sum[c] - SUM_BITS'(history[c][slot]) + SUM_BITS'(samples[c]);
            end else begin
                run_sum[c] = run_sum[c] + SUM_BITS'(samples[c]);
            end
            history[c][slot] = samples[c];
            avgs[c] = t_sample'(run_sum[c] / divisor);
        end
        if (full) begin
            oldest_slot = (slot + 1) % WINDOW;
        end
        return avgs;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_scan got;
        t_scan want;
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                run_sum[c] = '0;
            end
            fill_cnt    = '0;
            oldest_slot = 0;
            result_idx  = 0;
            expected_avgs.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[SCAN_BITS-1:0];
                if (expected_avgs.size() == 0) begin
                    report_mismatch($sformatf("result transaction with no scan pending, data %h",
                                              got));
                end else begin
                    want = expected_avgs.pop_front();
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (got[c] !== want[c]) begin
                            report_mismatch($sformatf("avg_ch%0d got %0d, expected %0d",
                                                      c, got[c], want[c]));
                        end
                    end
                end
                result_idx++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_avgs.push_back(predict_averages(i_s_axis_tdata[SCAN_BITS-1:0]));
            end
        end
        o_pending = expected_avgs.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Moving average core testbench
// Drives directed and random ADC scans into the core with random gaps on
// both stream sides, bursts without gaps and one long output stall, and
// takes the verdict from the result checker once every result has arrived.
// ----------------------------------------------------------------------------
module tb_top;
    import mcma_pkg::*;

    localparam int WINDOW       = 8;
    localparam int MAX_GAP      = 17;
    localparam int RANDOM_SCANS = 700;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 10;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int results_seen = 0;
    int send_burst   = 0;
    int recv_burst   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multichannel_moving_average_core #(
        .WINDOW (WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mcma_avg_checker #(
        .WINDOW (WINDOW)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_scan uniform_scan(input t_sample value);
        t_scan scan;
        for (int c = 0; c < CHANNELS; c++) begin
            scan[c] = value;
        end
        return scan;
    endfunction

    function automatic t_scan random_scan();
        t_scan scan;
        for (int c = 0; c < CHANNELS; c++) begin
            case ($urandom_range(0, 7))
                0: begin
                    scan[c] = '0;
                end
                1: begin
                    scan[c] = '1;
                end
                default: begin
                    scan[c] = t_sample'($urandom_range(0, 4095));
                end
            endcase
        end
        return scan;
    endfunction

    task automatic send_scan(input t_scan scan);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= TDATA_W'(scan);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin : sink
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_seen == HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            results_seen++;
        end
    end

    initial begin : source
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first scan after reset averages over itself alone.
        send_scan(uniform_scan(12'h000));
        send_scan(uniform_scan(12'hFFF));
        send_scan({12'h000, 12'hFFF, 12'h555, 12'hAAA});
        send_scan({12'hFFF, 12'h000, 12'hAAA, 12'h555});
        send_scan({12'd2047, 12'd2048, 12'd4094, 12'd1});
        send_scan({12'd1, 12'd4094, 12'd2048, 12'd2047});
        send_scan({12'h800, 12'h7FF, 12'h001, 12'hFFE});
        send_scan({12'h123, 12'h456, 12'h789, 12'hABC});
        // A full window of maximum samples drives the sums to their largest value.
        repeat (WINDOW) send_scan(uniform_scan(12'hFFF));
        repeat (5) send_scan(uniform_scan(12'h000));

        for (int i = 0; i < RANDOM_SCANS; i++) begin
            send_scan(random_scan());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mcma_pkg.sv
rtl/mcma_cell.sv
rtl/mcma_div.sv
rtl/multichannel_moving_average_core.sv
tb/sv/mcma_avg_checker.sv
tb/sv/tb_top.sv
